FILE: sv/lhmu_pkg.sv
// Shared types and constants for the lattice hint make/use block.
package lhmu_pkg;

  localparam int unsigned WORD_W    = 32;
  localparam int unsigned CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_MODULUS_Q  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HALF_GAMMA = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RECIP_MULT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RECIP_SHFT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA      = 3'd4;

  localparam logic REQ_MAKE = 1'b0;
  localparam logic REQ_USE  = 1'b1;

  localparam logic [18:0] MODULUS_Q_RST = 19'd520193;
  localparam logic [15:0] ALPHA_RST     = 16'd2;

  typedef logic [WORD_W-1:0] word_t;

  typedef struct packed {
    logic  req_type;
    word_t w_coef;
    word_t z2_coef;
    word_t b0c_coef;
    word_t chal_coef;
    logic  is_first_row;
    logic  b_flag;
    word_t w1_coef;
    word_t hint_in;
  } item_t;

  typedef struct packed {
    logic  req_type;
    word_t w1_coef;
    word_t hint_in;
  } side_t;

endpackage

FILE: sv/lattice_hint_make_and_use_top.sv
// Top level of the lattice hint make/use block: config registers and pipeline control.
// Six-stage pipeline, one item per cycle sustained while out_ready is high. An item
// accepted on in_valid/in_ready shows on out_valid after these stages: input register,
// mix sum, q lift and offset, 32x32 reciprocal multiply, shift and class wrap, result
// register. Stages move independently, so bubbles close up and in_ready stays high while
// any stage has room, also while a finished result waits on out_ready. Configuration
// registers are read by the stages directly and may be written only when the pipeline
// is empty; a write to an index above 4 is ignored.
module lattice_hint_make_and_use_top (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [lhmu_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [31:0]                     cfg_wdata,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            in_req_type,
  input  logic signed [31:0]              in_w_coef,
  input  logic signed [31:0]              in_z2_coef,
  input  logic signed [31:0]              in_b0c_coef,
  input  logic signed [31:0]              in_chal_coef,
  input  logic                            in_is_first_row,
  input  logic                            in_b_flag,
  input  logic signed [31:0]              in_w1_coef,
  input  logic signed [31:0]              in_hint_in,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic signed [31:0]              out_result_value
);
  import lhmu_pkg::*;

  localparam int unsigned NSTG   = 6;
  localparam int unsigned ST_IN  = 0;
  localparam int unsigned ST_MIX = 1;
  localparam int unsigned ST_OFS = 2;
  localparam int unsigned ST_MUL = 3;
  localparam int unsigned ST_HB  = 4;
  localparam int unsigned ST_OUT = 5;

  logic [18:0] modulus_q_r;
  logic [17:0] half_gamma_r;
  logic [31:0] recip_mult_r;
  logic [5:0]  recip_shift_r;
  logic [15:0] alpha_r;

  logic [NSTG-1:0] vld_r, vld_nxt;
  logic [NSTG-1:0] rdy;
  logic [NSTG-1:0] load;

  item_t item_in;
  item_t item_r;
  word_t r_nxt, r_r;
  word_t s_nxt, s_r;
  word_t hb;
  word_t res_nxt, res_r;
  side_t side_in;
  side_t side_mix_r, side_ofs_r, side_mul_r, side_hb_r;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      modulus_q_r   <= MODULUS_Q_RST;
      half_gamma_r  <= '0;
      recip_mult_r  <= '0;
      recip_shift_r <= '0;
      alpha_r       <= ALPHA_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MODULUS_Q:  modulus_q_r   <= cfg_wdata[18:0];
        CFG_HALF_GAMMA: half_gamma_r  <= cfg_wdata[17:0];
        CFG_RECIP_MULT: recip_mult_r  <= cfg_wdata;
        CFG_RECIP_SHFT: recip_shift_r <= cfg_wdata[5:0];
        CFG_ALPHA:      alpha_r       <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  // pipeline flow control
  always_comb begin
    rdy[NSTG-1] = !vld_r[NSTG-1] || out_ready;
    for (int i = NSTG - 2; i >= 0; i--) begin
      rdy[i] = !vld_r[i] || rdy[i+1];
    end
    load[0] = in_valid && rdy[0];
    for (int i = 1; i < NSTG; i++) begin
      load[i] = vld_r[i-1] && rdy[i];
    end
    for (int i = 0; i < NSTG; i++) begin
      vld_nxt[i] = rdy[i] ? load[i] : vld_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign item_in = '{
    req_type:     in_req_type,
    w_coef:       in_w_coef,
    z2_coef:      in_z2_coef,
    b0c_coef:     in_b0c_coef,
    chal_coef:    in_chal_coef,
    is_first_row: in_is_first_row,
    b_flag:       in_b_flag,
    w1_coef:      in_w1_coef,
    hint_in:      in_hint_in
  };

  assign side_in = '{
    req_type: item_r.req_type,
    w1_coef:  item_r.w1_coef,
    hint_in:  item_r.hint_in
  };

  lhmu_mix u_mix (
    .item (item_r),
    .r    (r_nxt)
  );

  lhmu_offset u_offset (
    .r          (r_r),
    .modulus_q  (modulus_q_r),
    .half_gamma (half_gamma_r),
    .s          (s_nxt)
  );

  lhmu_hbits u_hbits (
    .clk         (clk),
    .mul_en      (load[ST_MUL]),
    .hb_en       (load[ST_HB]),
    .s           (s_r),
    .recip_mult  (recip_mult_r),
    .recip_shift (recip_shift_r),
    .alpha       (alpha_r),
    .hb          (hb)
  );

  lhmu_final u_final (
    .hb    (hb),
    .side  (side_hb_r),
    .alpha (alpha_r),
    .res   (res_nxt)
  );

  // payload registers
  always_ff @(posedge clk) begin
    if (load[ST_IN]) begin
      item_r <= item_in;
    end
    if (load[ST_MIX]) begin
      r_r        <= r_nxt;
      side_mix_r <= side_in;
    end
    if (load[ST_OFS]) begin
      s_r        <= s_nxt;
      side_ofs_r <= side_mix_r;
    end
    if (load[ST_MUL]) begin
      side_mul_r <= side_ofs_r;
    end
    if (load[ST_HB]) begin
      side_hb_r <= side_mul_r;
    end
    if (load[ST_OUT]) begin
      res_r <= res_nxt;
    end
  end

  assign in_ready         = rdy[ST_IN];
  assign out_valid        = vld_r[ST_OUT];
  assign out_result_value = res_r;

  // in_ready drops only when every stage is full and the result is stalled
  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (out_valid && !out_ready && (vld_r == '1)))
    else $error("in_ready low without a full stalled pipeline");

  // items in flight change only by accepted inputs and delivered results
  a_occupancy: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |->
      ($countones(vld_r) + $past(out_valid && out_ready)
       == $past($countones(vld_r)) + $past(in_valid && in_ready)))
    else $error("pipeline occupancy mismatch");

  // an item entering an empty pipeline passes every stage and reaches the output
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && (vld_r == '0)) |-> ##6 out_valid)
    else $error("item did not reach the output in time");

endmodule

FILE: sv/lhmu_mix.sv
// Forms the value whose high bits are taken: w - z2 + b0c (+ chal) or w.
module lhmu_mix (
  input  lhmu_pkg::item_t item,
  output lhmu_pkg::word_t r
);
  import lhmu_pkg::*;

  logic  chal_en;
  word_t chal_term;
  word_t make_val;

  assign chal_en   = item.is_first_row && !item.b_flag;
  assign chal_term = chal_en ? item.chal_coef : '0;
  assign make_val  = (item.w_coef - item.z2_coef) + item.b0c_coef + chal_term;
  assign r         = (item.req_type == REQ_MAKE) ? make_val : item.w_coef;

endmodule

FILE: sv/lhmu_offset.sv
// Lifts a negative value by q and adds the rounding offset.
module lhmu_offset (
  input  lhmu_pkg::word_t r,
  input  logic [18:0]     modulus_q,
  input  logic [17:0]     half_gamma,
  output lhmu_pkg::word_t s
);
  import lhmu_pkg::*;

  word_t v;

  assign v = r + (r[WORD_W-1] ? {13'd0, modulus_q} : '0);
  assign s = v + {14'd0, half_gamma};

endmodule

FILE: sv/lhmu_hbits.sv
// Reciprocal multiply, shift and class wrap: two pipeline stages.
module lhmu_hbits (
  input  logic            clk,
  input  logic            mul_en,
  input  logic            hb_en,
  input  lhmu_pkg::word_t s,
  input  logic [31:0]     recip_mult,
  input  logic [5:0]      recip_shift,
  input  logic [15:0]     alpha,
  output lhmu_pkg::word_t hb
);
  import lhmu_pkg::*;

  logic [2*WORD_W-1:0] prod_r, prod_nxt;
  logic [2*WORD_W-1:0] shifted;
  word_t               hb_raw;
  word_t               alpha_w;
  word_t               diff;
  word_t               hb_r, hb_nxt;

  assign prod_nxt = (2*WORD_W)'(s) * (2*WORD_W)'(recip_mult);

  assign alpha_w = {16'd0, alpha};
  assign shifted = prod_r >> recip_shift;
  assign hb_raw  = shifted[WORD_W-1:0];
  assign diff    = alpha_w - (hb_raw + 32'd1);
  assign hb_nxt  = diff[WORD_W-1] ? (hb_raw - alpha_w) : hb_raw;

  always_ff @(posedge clk) begin
    if (mul_en) begin
      prod_r <= prod_nxt;
    end
    if (hb_en) begin
      hb_r <= hb_nxt;
    end
  end

  assign hb = hb_r;

endmodule

FILE: sv/lhmu_final.sv
// Centered hint (make) or recovered high bits (use) from hb.
module lhmu_final (
  input  lhmu_pkg::word_t hb,
  input  lhmu_pkg::side_t side,
  input  logic [15:0]     alpha,
  output lhmu_pkg::word_t res
);
  import lhmu_pkg::*;

  word_t alpha_w;
  word_t half_w;
  word_t h0, h1, over, h2;
  word_t v0, v1, v2, v3;

  assign alpha_w = {16'd0, alpha};
  assign half_w  = {17'd0, alpha[15:1]};

  assign h0   = side.w1_coef - hb;
  assign h1   = h0[WORD_W-1] ? (h0 + alpha_w) : h0;
  assign over = half_w - h1;
  assign h2   = over[WORD_W-1] ? (h1 - alpha_w) : h1;

  assign v0 = hb + side.hint_in;
  assign v1 = v0[WORD_W-1] ? (v0 + alpha_w) : v0;
  assign v2 = v1 - alpha_w;
  assign v3 = v2[WORD_W-1] ? (v2 + alpha_w) : v2;

  assign res = (side.req_type == REQ_MAKE) ? h2 : v3;

endmodule
